>>> src/huffman_symbol_encoder_bit_packer_unit_assert.svh
// ----------------------------------------------------------------------------
// huffman symbol encoder bit packer assertion macros
// Concurrent assertion wrappers used by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_SYMBOL_ENCODER_BIT_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_SYMBOL_ENCODER_BIT_PACKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that holds at every clock edge out of reset
`define HSEBP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define HSEBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSEBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define HSEBP_ASSERT(lbl, clk, rstn, prop, msg)
`define HSEBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define HSEBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> src/hsebp_pkg.sv
// ----------------------------------------------------------------------------
// hsebp_pkg
// Shared constants, codes and control types of the huffman encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsebp_pkg;

  // defaults for the top level parameters
  localparam int unsigned SYMBOLS_DEF      = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  // fixed field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned LEN_W     = 6;
  localparam int unsigned BYTE_W    = 8;

  // at most this many bytes leave per request
  localparam int unsigned RESULT_LIMIT = 4;
  localparam int unsigned RES_CNT_W    = 3;

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  // controller to datapath commands
  typedef struct packed {
    logic tab_write;
    logic tab_read;
    logic item_start;
    logic flush_start;
    logic align;
    logic merge;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic partial_empty;
    logic len_zero;
    logic avail_ge8;
    logic drop;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/hsebp_if.sv
// ----------------------------------------------------------------------------
// hsebp_in_if / hsebp_out_if
// Valid-ready channels carrying encoder requests and packed bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface hsebp_in_if
  import hsebp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_value;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, opcode, symbol, code_value, code_length, input ready);
  modport sink   (input valid, opcode, symbol, code_value, code_length, output ready);
endinterface

interface hsebp_out_if
  import hsebp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/hsebp_ctrl.sv
// ----------------------------------------------------------------------------
// hsebp_ctrl
// Sequencer of the encoder: table access, alignment, merge and byte output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsebp_ctrl
  import hsebp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] opcode_i,
  input  wire dp_status_t      status_i,
  output logic                 in_ready_o,
  output dp_cmd_t              cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ALIGN = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_LOAD: begin
              cmd_o.tab_write = 1'b1;
            end
            OP_ENCODE: begin
              cmd_o.tab_read   = 1'b1;
              cmd_o.item_start = 1'b1;
              state_d          = ST_ALIGN;
            end
            OP_FLUSH: begin
              if (!status_i.partial_empty) begin
                cmd_o.flush_start = 1'b1;
                cmd_o.item_start  = 1'b1;
                state_d           = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ALIGN: begin
        // symbols without a code leave the packer untouched
        if (status_i.len_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.align = 1'b1;
          state_d     = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.avail_ge8) begin
          state_d = ST_IDLE;
        end else if (status_i.drop || !status_i.out_busy) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/hsebp_dp.sv
// ----------------------------------------------------------------------------
// hsebp_dp
// Code table, bit window with fill count, and the output byte register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_symbol_encoder_bit_packer_unit_assert.svh"

module hsebp_dp
  import hsebp_pkg::*;
#(
  parameter int unsigned SYMBOLS      = SYMBOLS_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [CODE_W-1:0] code_value_i,
  input  wire logic [LEN_W-1:0]  code_length_i,
  input  wire dp_cmd_t           cmd_i,
  input  wire logic              out_ready_i,
  output dp_status_t             status_o,
  output logic                   out_valid_o,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   out_last_o
);

  localparam int unsigned IDX_W    = $clog2(SYMBOLS);
  localparam int unsigned LEN_Q_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned CODE_Q_W = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned ENTRY_W  = LEN_Q_W + CODE_Q_W;
  localparam int unsigned WIN_W    = MAX_CODE_LEN + BYTE_W;
  localparam int unsigned AV_W     = $clog2(WIN_W + 1);
  localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOLS);

  logic                 sym_ok;
  logic [IDX_W-1:0]     idx;
  logic [LEN_Q_W-1:0]   len_clamp;
  logic [ENTRY_W-1:0]   table_mem [SYMBOLS];
  logic [SYMBOLS-1:0]   valid_q;
  logic [ENTRY_W-1:0]   rd_data_q;
  logic                 rd_hit_q;
  logic [LEN_Q_W-1:0]   len_rd;
  logic [CODE_Q_W-1:0]  code_rd;
  logic [WIN_W-1:0]     code_left_q;
  logic [LEN_Q_W-1:0]   len_q;
  logic [WIN_W-1:0]     win_q, win_d;
  logic [AV_W-1:0]      avail_q, avail_d;
  logic [AV_W-1:0]      avail_less;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic                 drop;
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic                 out_last_q;

  // request decode
  assign sym_ok    = {1'b0, symbol_i} < SYM_LIMIT;
  assign idx       = symbol_i[IDX_W-1:0];
  assign len_clamp = (code_length_i > LEN_W'(MAX_CODE_LEN)) ? LEN_Q_W'(MAX_CODE_LEN)
                                                            : code_length_i[LEN_Q_W-1:0];

  // code table, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.tab_write && sym_ok) begin
      table_mem[idx] <= {len_clamp, code_value_i[CODE_Q_W-1:0]};
    end
    if (cmd_i.tab_read) begin
      rd_data_q <= table_mem[idx];
    end
  end

  // written-entry flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (cmd_i.tab_write && sym_ok) begin
        valid_q[idx] <= 1'b1;
      end
      if (cmd_i.tab_read) begin
        rd_hit_q <= sym_ok && valid_q[idx];
      end
    end
  end

  assign len_rd  = rd_data_q[ENTRY_W-1 -: LEN_Q_W];
  assign code_rd = rd_data_q[CODE_Q_W-1:0];

  // left-align the code in the window width
  always_ff @(posedge clk_i) begin
    if (cmd_i.align) begin
      code_left_q <= WIN_W'(code_rd) << (AV_W'(WIN_W) - AV_W'(len_rd));
      len_q       <= len_rd;
    end
  end

  // bit window: pending bits left-aligned, zeros below the fill count
  assign avail_less = avail_q - AV_W'(BYTE_W);

  always_comb begin
    win_d   = win_q;
    avail_d = avail_q;
    if (cmd_i.flush_start) begin
      avail_d = AV_W'(BYTE_W);
    end else if (cmd_i.merge) begin
      win_d   = win_q | (code_left_q >> avail_q[2:0]);
      avail_d = avail_q + AV_W'(len_q);
    end else if (cmd_i.emit) begin
      win_d   = win_q << BYTE_W;
      avail_d = avail_less;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      avail_q <= '0;
    end else begin
      win_q   <= win_d;
      avail_q <= avail_d;
    end
  end

  // bytes delivered for the current request
  assign drop = (res_cnt_q == RES_CNT_W'(RESULT_LIMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
    end else if (cmd_i.item_start) begin
      res_cnt_q <= '0;
    end else if (cmd_i.emit && !drop) begin
      res_cnt_q <= res_cnt_q + RES_CNT_W'(1);
    end
  end

  // output byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && !drop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && !drop) begin
      out_byte_q <= win_q[WIN_W-1 -: BYTE_W];
      out_last_q <= (avail_less < AV_W'(BYTE_W)) ||
                    (res_cnt_q == RES_CNT_W'(RESULT_LIMIT - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // status to the controller
  assign status_o.partial_empty = (avail_q == '0);
  assign status_o.len_zero      = !rd_hit_q || (len_rd == '0);
  assign status_o.avail_ge8     = (avail_q >= AV_W'(BYTE_W));
  assign status_o.drop          = drop;
  assign status_o.out_busy      = out_valid_q && !out_ready_i;

  // checks
  `HSEBP_ASSERT(a_tail_zero, clk_i, rst_ni, (win_q << avail_q) == '0, "window bits past fill count not zero")
  `HSEBP_ASSERT(a_avail_range, clk_i, rst_ni, avail_q <= AV_W'(WIN_W - 1), "fill count beyond window")
  `HSEBP_ASSERT(a_res_limit, clk_i, rst_ni, res_cnt_q <= RES_CNT_W'(RESULT_LIMIT), "too many bytes for one request")
  `HSEBP_ASSERT_IMPL(a_slot_free, clk_i, rst_ni, cmd_i.emit && !drop, !out_valid_q || out_ready_i, "byte overwrites a waiting byte")
  `HSEBP_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd_i.emit && !drop, out_valid_q, "emitted byte not presented")

endmodule

`default_nettype wire

>>> src/huffman_symbol_encoder_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_symbol_encoder_bit_packer_unit
// Table-driven huffman encoder with an msb-first byte packer.
// ----------------------------------------------------------------------------
// usage
//   in_i carries requests: load writes one table entry (code and length),
//   encode appends the symbol's code bits to the packer, flush pads the
//   pending bits with zeros to a byte. out_o carries packed bytes, earliest
//   bit in bit 7, last_of_run marking the final byte of a request.
// sequence
//   one request is in work at a time. a load writes one entry. an encode
//   does a table read, an alignment shift and a merge into the bit window,
//   then one byte per cycle out of the window unless the output stalls. a
//   flush of pending bits goes straight to output; an empty flush or a
//   symbol without code leaves the packer untouched. the first byte shows
//   in the cycle after it leaves the window, through the output register.
// reset
//   all code lengths read as zero and the packer is empty; code bits of an
//   entry stay unknown until it is loaded. no clearing pass is needed.
// stall
//   a waiting byte is held in the output register; the next request is
//   taken while it waits, but the window stops until the byte is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_symbol_encoder_bit_packer_unit
  import hsebp_pkg::*;
#(
  parameter int unsigned SYMBOLS      = SYMBOLS_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsebp_in_if.sink    in_i,
  hsebp_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  // sequencer
  hsebp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // table, window and output register
  hsebp_dp #(
    .SYMBOLS      (SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .symbol_i      (in_i.symbol),
    .code_value_i  (in_i.code_value),
    .code_length_i (in_i.code_length),
    .cmd_i         (cmd),
    .out_ready_i   (out_o.ready),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_byte_o    (out_o.out_byte),
    .out_last_o    (out_o.last_of_run)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire
